>>> hw/rtl/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants for the streaming KMP matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned BYTE_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  localparam logic KIND_TEXT    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic       restart;
    logic [7:0] text_byte;
  } item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_BWALK,
    S_BSET,
    S_WSTEP,
    S_WFIN
  } state_t;

endpackage

>>> hw/rtl/kmp_stream_matcher_core.sv
// ----------------------------------------------------------------------------
// kmp_stream_matcher_core
// Streaming KMP matcher with a strong failure table; pattern up to
// PATTERN_MAX bytes set through a write port.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): kind 0 carries a text byte, kind 1
// restarts matching at position zero. Output channel (out_valid/out_stall)
// returns one word per input word: match_found is 1 when the byte completes
// an occurrence (every byte for an empty pattern, 0 for a restart).
// Config: cfg_we writes cfg_data to register cfg_index (0 pattern bytes 0-7,
// 1 pattern bytes 8-15, 2 length); index 3 is ignored. A write to 0-2 clears the
// position and forces a table rebuild before the next word is processed.
// Steps: a restart or empty-pattern word is answered straight from idle; a
// text byte moves to S_WSTEP, which follows one failure link per step over
// the single-port failure table, and on a completed match on to S_WFIN.
// The engine takes one word at a time from the queue.
// A two-word input queue keeps accepting until full while the engine works;
// a stalled output holds its word and the engine waits before writing the
// next one. Reset clears configuration to zero, empties the queue and marks
// the table stale.
// ----------------------------------------------------------------------------
module kmp_stream_matcher_core #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [7:0]                     text_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           match_found
);

  logic           q_valid;
  logic           q_pop;
  kmp_pkg::item_t q_item;

  kmp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .text_byte (text_byte),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  kmp_back #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .match_found (match_found)
  );

endmodule

>>> hw/rtl/kmp_front.sv
// ----------------------------------------------------------------------------
// kmp_front
// Input side: accepts words, decodes the kind and holds them in a
// two-entry queue for the matching engine.
// ----------------------------------------------------------------------------
module kmp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           kind,
  input  logic [7:0]     text_byte,
  output logic           q_valid,
  output kmp_pkg::item_t q_item,
  input  logic           q_pop
);

  kmp_pkg::item_t q_mem [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     count;
  logic           push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr].restart   <= (kind == kmp_pkg::KIND_RESTART);
      q_mem[wr_ptr].text_byte <= text_byte;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> count != 2'd0)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count overflow");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push && !q_pop |=> count == $past(count) + 2'd1)
    else $error("queue count did not follow push");

endmodule

>>> hw/rtl/kmp_back.sv
// ----------------------------------------------------------------------------
// kmp_back
// Matching engine: holds configuration, rebuilds the strong failure table
// one step per cycle, walks failure links per text byte, registers result.
// ----------------------------------------------------------------------------
module kmp_back #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [kmp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kmp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             q_valid,
  input  kmp_pkg::item_t                   q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             match_found
);

  localparam int unsigned PW    = $clog2(PATTERN_MAX + 1);
  localparam int unsigned DEPTH = PATTERN_MAX + 1;

  logic [kmp_pkg::CFG_DATA_W-1:0] pattern_low;
  logic [kmp_pkg::CFG_DATA_W-1:0] pattern_high;
  logic [kmp_pkg::LEN_W-1:0]      pattern_length;
  logic [2*kmp_pkg::CFG_DATA_W-1:0] pat;

  kmp_pkg::state_t state, state_next;
  logic            stale;
  logic [PW:0]     ft [DEPTH];
  logic [PW-1:0]   mp, mp_next;
  logic [PW-1:0]   pos, pos_next;
  logic [7:0]      cur_byte;
  logic [PW-1:0]   i, i_next;
  logic [PW:0]     t, t_next;

  logic [PW-1:0]   len;
  logic [PW-1:0]   rd_addr;
  logic [PW:0]     ft_rd;
  logic            ft_clr;
  logic            ft_we;
  logic [PW-1:0]   ft_wa;
  logic [PW:0]     ft_wd;
  logic            out_free;
  logic            complete;
  logic            res;
  logic            mp_we;
  logic            load_item;
  logic            stale_clr;
  logic            bwalk_link;
  logic            wstep_hit;
  logic [PW:0]     pos_inc;

  function automatic logic [7:0] pbyte(input logic [PW-1:0] idx);
    logic [kmp_pkg::BYTE_IDX_W-1:0] k;
    k = kmp_pkg::BYTE_IDX_W'(idx);
    return pat[{k, 3'b000} +: 8];
  endfunction

  assign pat      = {pattern_high, pattern_low};
  assign len      = (pattern_length > kmp_pkg::LEN_W'(PATTERN_MAX)) ?
                    PW'(PATTERN_MAX) : PW'(pattern_length);
  assign out_free = !out_valid || !out_stall;
  assign ft_rd    = ft[rd_addr];

  always_comb begin
    bwalk_link = !t[PW] && (pbyte(i) != pbyte(t[PW-1:0]));
    wstep_hit  = (pbyte(pos) == cur_byte);
    pos_inc    = {1'b0, pos} + 1'b1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kmp_pkg::S_IDLE: begin
        if (stale) begin
          state_next = kmp_pkg::S_CLR;
        end else if (q_valid && out_free && !q_item.restart && len != '0) begin
          state_next = kmp_pkg::S_WSTEP;
        end
      end
      kmp_pkg::S_CLR:   state_next = (len == '0) ? kmp_pkg::S_IDLE : kmp_pkg::S_BWALK;
      kmp_pkg::S_BWALK: state_next = bwalk_link ? kmp_pkg::S_BWALK : kmp_pkg::S_BSET;
      kmp_pkg::S_BSET:  state_next = (i < len) ? kmp_pkg::S_BWALK : kmp_pkg::S_IDLE;
      kmp_pkg::S_WSTEP: begin
        if (wstep_hit) begin
          if (pos_inc == {1'b0, len}) begin
            state_next = kmp_pkg::S_WFIN;
          end else if (out_free) begin
            state_next = kmp_pkg::S_IDLE;
          end
        end else if (ft_rd[PW] && out_free) begin
          state_next = kmp_pkg::S_IDLE;
        end
      end
      kmp_pkg::S_WFIN: begin
        if (out_free) begin
          state_next = kmp_pkg::S_IDLE;
        end
      end
      default: state_next = kmp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    load_item = 1'b0;
    complete  = 1'b0;
    res       = 1'b0;
    mp_we     = 1'b0;
    mp_next   = mp;
    pos_next  = pos;
    i_next    = i;
    t_next    = t;
    ft_clr    = 1'b0;
    ft_we     = 1'b0;
    ft_wa     = i;
    ft_wd     = t;
    stale_clr = 1'b0;
    rd_addr   = t[PW-1:0];
    unique case (state)
      kmp_pkg::S_IDLE: begin
        if (!stale && q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_item.restart || len == '0) begin
            complete = 1'b1;
            res      = !q_item.restart;
            mp_we    = 1'b1;
            mp_next  = '0;
          end else begin
            load_item = 1'b1;
            pos_next  = (mp >= len) ? '0 : mp;
          end
        end
      end
      kmp_pkg::S_CLR: begin
        ft_clr    = 1'b1;
        stale_clr = 1'b1;
        i_next    = '0;
        t_next    = '1;
      end
      kmp_pkg::S_BWALK: begin
        if (bwalk_link) begin
          t_next = ft_rd;
        end else begin
          t_next = t + 1'b1;
          i_next = i + 1'b1;
        end
      end
      kmp_pkg::S_BSET: begin
        ft_we = 1'b1;
        if (i < len && pbyte(i) == pbyte(t[PW-1:0])) begin
          ft_wd = ft_rd;
        end
      end
      kmp_pkg::S_WSTEP: begin
        rd_addr = pos;
        if (wstep_hit) begin
          if (pos_inc != {1'b0, len} && out_free) begin
            complete = 1'b1;
            mp_we    = 1'b1;
            mp_next  = pos_inc[PW-1:0];
          end
        end else if (ft_rd[PW]) begin
          if (out_free) begin
            complete = 1'b1;
            mp_we    = 1'b1;
            mp_next  = '0;
          end
        end else begin
          pos_next = ft_rd[PW-1:0];
        end
      end
      kmp_pkg::S_WFIN: begin
        rd_addr = len;
        if (out_free) begin
          complete = 1'b1;
          res      = 1'b1;
          mp_we    = 1'b1;
          mp_next  = ft_rd[PW] ? '0 : ft_rd[PW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      state          <= kmp_pkg::S_IDLE;
      stale          <= 1'b1;
      mp             <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (complete) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we && (cfg_index == kmp_pkg::CFG_PATTERN_LOW ||
                     cfg_index == kmp_pkg::CFG_PATTERN_HIGH ||
                     cfg_index == kmp_pkg::CFG_PATTERN_LENGTH)) begin
        unique case (cfg_index)
          kmp_pkg::CFG_PATTERN_LOW:  pattern_low  <= cfg_data;
          kmp_pkg::CFG_PATTERN_HIGH: pattern_high <= cfg_data;
          default:                   pattern_length <= cfg_data[kmp_pkg::LEN_W-1:0];
        endcase
        state <= kmp_pkg::S_IDLE;
        stale <= 1'b1;
        mp    <= '0;
      end else begin
        state <= state_next;
        if (stale_clr) begin
          stale <= 1'b0;
        end
        if (mp_we) begin
          mp <= mp_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    i   <= i_next;
    t   <= t_next;
    if (load_item) begin
      cur_byte <= q_item.text_byte;
    end
    if (complete) begin
      match_found <= res;
    end
    if (ft_clr) begin
      for (int k = 0; k < DEPTH; k++) begin
        ft[k] <= '1;
      end
    end else if (ft_we) begin
      ft[ft_wa] <= ft_wd;
    end
  end

  a_cfg_stale: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == kmp_pkg::CFG_PATTERN_LOW ||
               cfg_index == kmp_pkg::CFG_PATTERN_HIGH ||
               cfg_index == kmp_pkg::CFG_PATTERN_LENGTH)
    |=> stale && state == kmp_pkg::S_IDLE && mp == '0)
    else $error("config write did not mark table stale");
  a_pop_ready: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == kmp_pkg::S_IDLE && !stale && out_free)
    else $error("item taken while engine busy or table stale");
  a_walk_pos: assert property (@(posedge clk) disable iff (rst)
    state == kmp_pkg::S_WSTEP |-> pos < len)
    else $error("walk position beyond pattern length");
  a_mp_range: assert property (@(posedge clk) disable iff (rst)
    state == kmp_pkg::S_IDLE && !stale |-> mp < len || mp == '0)
    else $error("match position out of range");
  a_complete_free: assert property (@(posedge clk) disable iff (rst)
    complete |-> out_free)
    else $error("result overwrote a waiting result");

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for kmp_stream_matcher_core. A directed table covers
// reset defaults, empty and saturated pattern lengths, overlapping matches,
// restarts and ignored register writes. Random phases then load patterns
// drawn from small alphabets and stream text that mostly replays the pattern.
// Each match_found word is checked against an in-bench strong-table KMP
// predictor, or against a fixed value for some directed rows, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [kmp_pkg::CFG_IDX_W-1:0] CFG_PATTERN_LOW    = kmp_pkg::CFG_PATTERN_LOW;
  localparam logic [kmp_pkg::CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = kmp_pkg::CFG_PATTERN_HIGH;
  localparam logic [kmp_pkg::CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = kmp_pkg::CFG_PATTERN_LENGTH;
  localparam logic KIND_TEXT    = kmp_pkg::KIND_TEXT;
  localparam logic KIND_RESTART = kmp_pkg::KIND_RESTART;

  localparam int unsigned PAT_MAX = 16;
  localparam logic [kmp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RAND_PHASES = 12;
  localparam int WORDS_PER_PHASE = 96;
  localparam int DIR_ROWS = 27;

  typedef enum logic {ROW_WRITE, ROW_WORD} row_op_t;

  typedef struct packed {
    row_op_t                       op;
    logic [kmp_pkg::CFG_IDX_W-1:0] idx;
    logic [63:0]                   data;
    logic                          k;
    logic [7:0]                    b;
    logic                          fixed;
    logic                          want;
  } row_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [kmp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kmp_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic                           kind;
  logic [7:0]                     text_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic                           match_found;

  kmp_stream_matcher_core #(.PATTERN_MAX(PAT_MAX)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .text_byte   (text_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .match_found (match_found)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [63:0] pat_lo_q;
  logic [63:0] pat_hi_q;
  logic [4:0]  pat_len_q;
  int          pos_q;
  int          fail_tab [PAT_MAX+1];
  bit          stale_q;

  logic        expected_matches [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          idle_on;
  int          stall_left = 0;
  logic [7:0]  alphabet [3];

  row_t directed_rows [DIR_ROWS] = '{
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'h00, 1'b1, 1'b1},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'hFF, 1'b1, 1'b1},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_RESTART, 8'hA5, 1'b1, 1'b0},
    '{ROW_WRITE, CFG_PATTERN_LOW,    64'h0000_0000_0061_6161, KIND_TEXT,    8'h00, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE3, KIND_TEXT,    8'h00, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'h61, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'h61, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_UNUSED,         64'hDEAD_BEEF_0123_4567, KIND_TEXT,    8'h00, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'h61, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'h61, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'h62, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_RESTART, 8'h61, 1'b1, 1'b0},
    '{ROW_WRITE, CFG_PATTERN_HIGH,   64'hFFFF_FFFF_FFFF_FFFF, KIND_TEXT,    8'h00, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_PATTERN_LOW,    64'hFFFF_FFFF_FFFF_FFFF, KIND_TEXT,    8'h00, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_PATTERN_LENGTH, 64'h0000_0000_0000_001F, KIND_TEXT,    8'h00, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'hFF, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'hFF, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'h00, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_PATTERN_LENGTH, 64'h0,                   KIND_TEXT,    8'h00, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'h5A, 1'b1, 1'b1},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_RESTART, 8'h00, 1'b1, 1'b0},
    '{ROW_WRITE, CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'h00, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_PATTERN_LENGTH, 64'h1,                   KIND_TEXT,    8'h00, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'h00, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'h01, 1'b0, 1'b0},
    '{ROW_WRITE, CFG_PATTERN_LENGTH, 64'h10,                  KIND_TEXT,    8'h00, 1'b0, 1'b0},
    '{ROW_WORD,  CFG_PATTERN_LOW,    64'h0,                   KIND_TEXT,    8'h00, 1'b0, 1'b0}
  };

  function automatic logic [7:0] pat_at(int i);
    int k;
    k = i & 15;
    return (k < 8) ? pat_lo_q[8*k +: 8] : pat_hi_q[8*(k-8) +: 8];
  endfunction

  function automatic int eff_len();
    return (pat_len_q > 5'd16) ? 16 : int'(pat_len_q);
  endfunction

  function automatic void rebuild_fail_tab();
    int len;
    int i;
    int t;
    len = eff_len();
    i = 0;
    t = -1;
    for (int k = 0; k <= PAT_MAX; k++) fail_tab[k] = -1;
    stale_q = 1'b0;
    while (i < len) begin
      while (t > -1 && pat_at(i) != pat_at(t)) t = fail_tab[t];
      t++;
      i++;
      if (i < len && pat_at(i) == pat_at(t)) fail_tab[i] = fail_tab[t];
      else fail_tab[i] = t;
    end
  endfunction

  function automatic logic predict_match(logic k, logic [7:0] b);
    int len;
    int p;
    if (stale_q) rebuild_fail_tab();
    len = eff_len();
    if (k == KIND_RESTART) begin
      pos_q = 0;
      return 1'b0;
    end
    if (len == 0) begin
      pos_q = 0;
      return 1'b1;
    end
    p = pos_q;
    if (p < 0 || p >= len) p = 0;
    while (p >= 0 && pat_at(p) != b) p = fail_tab[p];
    p++;
    if (p == len) begin
      pos_q = (fail_tab[len] < 0) ? 0 : fail_tab[len];
      return 1'b1;
    end
    pos_q = p;
    return 1'b0;
  endfunction

  function automatic void apply_reg_write(logic [kmp_pkg::CFG_IDX_W-1:0] idx,
                                          logic [63:0] data);
    case (idx)
      CFG_PATTERN_LOW:    pat_lo_q = data;
      CFG_PATTERN_HIGH:   pat_hi_q = data;
      CFG_PATTERN_LENGTH: pat_len_q = data[4:0];
      default:            return;
    endcase
    stale_q = 1'b1;
    pos_q = 0;
  endfunction

  // waits for the pipe to drain, then writes one register
  task automatic write_reg(input logic [kmp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_data <= {$urandom, $urandom};
    apply_reg_write(idx, data);
  endtask

  task automatic send_word(input logic k, input logic [7:0] b, input logic fixed,
                           input logic want);
    logic pred;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    text_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_match(k, b);
    expected_matches.push_back(fixed ? want : pred);
    @(negedge clk);
  endtask

  task automatic random_config();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] lenval;
    logic [7:0]  pb;
    int          r;
    for (int j = 0; j < 3; j++) alphabet[j] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) alphabet[2] = alphabet[0];
    lo = '0;
    hi = '0;
    for (int j = 0; j < 16; j++) begin
      pb = ($urandom_range(0, 9) != 0) ? alphabet[$urandom_range(0, 2)]
                                       : 8'($urandom_range(0, 255));
      if (j < 8) lo[8*j +: 8] = pb;
      else hi[8*(j-8) +: 8] = pb;
    end
    lenval = {$urandom, $urandom};
    r = $urandom_range(0, 19);
    case (r)
      0:       lenval[4:0] = 5'd0;
      1:       lenval[4:0] = 5'd16;
      2:       lenval[4:0] = 5'($urandom_range(17, 31));
      3:       lenval[4:0] = 5'($urandom_range(0, 31));
      default: lenval[4:0] = 5'($urandom_range(1, 6));
    endcase
    if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0:       write_reg(CFG_PATTERN_LOW, lo);
        1:       write_reg(CFG_PATTERN_HIGH, hi);
        default: write_reg(CFG_PATTERN_LENGTH, lenval);
      endcase
    end else if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_PATTERN_LENGTH, lenval);
      write_reg(CFG_PATTERN_LOW, lo);
      write_reg(CFG_PATTERN_HIGH, hi);
    end else begin
      write_reg(CFG_PATTERN_HIGH, hi);
      write_reg(CFG_PATTERN_LOW, lo);
      write_reg(CFG_PATTERN_LENGTH, lenval);
    end
  endtask

  // mostly pattern replays with random offsets and corruption, plus noise
  task automatic random_text(input int n_words);
    int         feed;
    int         len;
    int         r;
    logic       k;
    logic [7:0] b;
    feed = PAT_MAX + 1;
    for (int w = 0; w < n_words; w++) begin
      len = eff_len();
      if (feed >= len && len > 0 && $urandom_range(0, 2) == 0)
        feed = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : 0;
      k = KIND_TEXT;
      if (feed < len) begin
        b = pat_at(feed);
        feed++;
        if ($urandom_range(0, 29) == 0) b = 8'($urandom_range(0, 255));
      end else begin
        r = $urandom_range(0, 99);
        b = 8'($urandom_range(0, 255));
        if (r < 5) begin
          k = KIND_RESTART;
          feed = PAT_MAX + 1;
        end else if (r >= 20) begin
          b = alphabet[$urandom_range(0, 2)];
        end
      end
      send_word(k, b, 1'b0, 1'b0);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0 && idle_on) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && !rst && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end
  end

  always @(posedge clk) begin
    logic want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: match_found expected none, got %0b", $time, match_found);
        fail_count++;
      end else begin
        want = expected_matches.pop_front();
        if (match_found !== want) begin
          $display("%0t: match_found expected %0b, got %0b", $time, want, match_found);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_PATTERN_LOW;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KIND_TEXT;
    text_byte = 8'h00;
    out_stall = 1'b0;
    idle_on = 1'b1;
    pat_lo_q = '0;
    pat_hi_q = '0;
    pat_len_q = '0;
    pos_q = 0;
    stale_q = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (directed_rows[i].op == ROW_WRITE)
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      else
        send_word(directed_rows[i].k, directed_rows[i].b, directed_rows[i].fixed,
                  directed_rows[i].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_on = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      random_config();
      random_text(WORDS_PER_PHASE);
    end

    in_valid <= 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/kmp_pkg.sv
hw/rtl/kmp_front.sv
hw/rtl/kmp_back.sv
hw/rtl/kmp_stream_matcher_core.sv
test/tb.sv
